### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define SPQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication: when the trigger holds, the consequence holds in the next cycle.
`define SPQ_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`else

`define SPQ_ASSERT(label, prop, msg)
`define SPQ_ASSERT_NEXT(label, trig, cons, msg)

`endif

`endif

### rtl/core/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue modules.
// ---------------------------------------------------------------------------
package spq_pkg;

	localparam int PID_W = 16;
	localparam int PRI_W = 16;
	localparam int OCC_W = 5;

	// Operation codes carried on the request tuser.
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	// One stored entry.
	typedef struct packed {
		logic [PRI_W-1:0] priority_val;
		logic [PID_W-1:0] proc_id;
	} spq_entry_t;

	// Commands from the controller to the slot array.
	typedef struct packed {
		logic insert;
		logic remove;
	} spq_cmd_t;

endpackage

### rtl/core/spq_datapath.sv
// ---------------------------------------------------------------------------
// spq_datapath
// Row of entry cells kept in descending priority order; each cell compares
// its priority with the incoming one and shifts in place.
// ---------------------------------------------------------------------------
module spq_datapath import spq_pkg::*; #(
	parameter int CAPACITY = 16,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic       clk,
	input  spq_cmd_t   cmd,
	input  logic [CW-1:0] count,
	input  spq_entry_t new_entry,
	output spq_entry_t head
);

	spq_entry_t slot_q [CAPACITY];
	logic [CAPACITY-1:0] below;  // stored entry ranks after the new one (or is empty)

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			assign below[i] = (CW'(i) >= count) ||
				($signed(slot_q[i].priority_val) < $signed(new_entry.priority_val));

			if (i == 0) begin : g_first
				always_ff @(posedge clk) begin
					if (cmd.insert && below[i]) begin
						slot_q[i] <= new_entry;
					end else if (cmd.remove) begin
						if (CAPACITY > 1) begin
							slot_q[i] <= slot_q[(CAPACITY > 1) ? 1 : 0];
						end
					end
				end
			end else begin : g_rest
				always_ff @(posedge clk) begin
					if (cmd.insert && below[i]) begin
						// The first cell that ranks below takes the new entry.
						slot_q[i] <= below[i-1] ? slot_q[i-1] : new_entry;
					end else if (cmd.remove && (i < CAPACITY - 1)) begin
						slot_q[i] <= slot_q[(i < CAPACITY - 1) ? i + 1 : i];
					end
				end
			end
		end
	endgenerate

	assign head = slot_q[0];

endmodule

### rtl/core/spq_ctrl.sv
// ---------------------------------------------------------------------------
// spq_ctrl
// Controller: handshake, fill-level state machine, entry count and the
// registered result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_ctrl import spq_pkg::*; #(
	parameter int CAPACITY = 16,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic          func,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic          head_valid,
	output spq_entry_t    head_entry,
	output logic          overflow,
	output logic [OCC_W-1:0] occupancy,
	output spq_cmd_t      cmd,
	output logic [CW-1:0] count,
	input  spq_entry_t    dp_head
);

	typedef enum logic [1:0] {
		ST_EMPTY,
		ST_PARTIAL,
		ST_FULL
	} state_t;

	state_t        state_q, state_next;
	logic [CW-1:0] count_q, count_next;
	logic          m_tvalid_q;
	logic          head_valid_q, overflow_q;
	spq_entry_t    head_q;
	logic          accept;
	logic [CW+OCC_W-1:0] count_ext;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign cmd.insert = accept && (func == FUNC_INSERT) && (state_q != ST_FULL);
	assign cmd.remove = accept && (func == FUNC_REMOVE) && (state_q != ST_EMPTY);

	always_comb begin
		count_next = count_q;
		if (cmd.insert) begin
			count_next = count_q + CW'(1);
		end else if (cmd.remove) begin
			count_next = count_q - CW'(1);
		end
		if (count_next == CW'(0)) begin
			state_next = ST_EMPTY;
		end else if (count_next == CW'(CAPACITY)) begin
			state_next = ST_FULL;
		end else begin
			state_next = ST_PARTIAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_EMPTY;
			count_q      <= '0;
			m_tvalid_q   <= 1'b0;
			head_valid_q <= 1'b0;
			overflow_q   <= 1'b0;
			head_q       <= '0;
		end else begin
			if (accept) begin
				state_q      <= state_next;
				count_q      <= count_next;
				m_tvalid_q   <= 1'b1;
				head_valid_q <= cmd.remove;
				overflow_q   <= (func == FUNC_INSERT) && (state_q == ST_FULL);
				head_q       <= cmd.remove ? dp_head : '0;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// The count only moves on an accepted request, so it always matches the
	// result currently held at the output.
	assign count_ext  = {{OCC_W{1'b0}}, count_q};
	assign occupancy  = count_ext[OCC_W-1:0];
	assign count      = count_q;
	assign m_tvalid   = m_tvalid_q;
	assign head_valid = head_valid_q;
	assign head_entry = head_q;
	assign overflow   = overflow_q;

	`SPQ_ASSERT(a_full_state, (state_q == ST_FULL) == (count_q == CW'(CAPACITY)), "full state and count disagree")
	`SPQ_ASSERT(a_empty_state, (state_q == ST_EMPTY) == (count_q == CW'(0)), "empty state and count disagree")
	`SPQ_ASSERT_NEXT(a_insert_count, cmd.insert, count_q == $past(count_q) + CW'(1), "insert did not grow count")
	`SPQ_ASSERT_NEXT(a_remove_count, cmd.remove, count_q == $past(count_q) - CW'(1), "remove did not shrink count")
	`SPQ_ASSERT(a_flags_excl, !(m_tvalid_q && head_valid_q && overflow_q), "head and overflow flags both set")

endmodule

### rtl/core/sorted_priority_queue.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue of (process id, priority) entries, highest first.
// ---------------------------------------------------------------------------
// Usage: each request on the s_ channel carries an operation in s_tuser.
// An insert stores the entry behind every entry of greater or equal priority,
// so equal priorities leave in arrival order. A remove returns the head entry
// and drops it. Every request produces exactly one result on the m_ channel.
// An insert into a full queue is dropped and reported with the overflow flag;
// a remove from an empty queue returns head_valid low with zero fields.
// The result is registered at the edge that accepts the request. Throughput
// is one request per cycle while m_tready holds; the entry row is a line of
// cells that each compare and shift in parallel, so an insert or a remove
// completes in the accepting cycle whatever the fill level.
// Reset empties the queue at once; stored entries need no clearing because
// only cells below the count are ever read.
// When the receiver stalls, the result stays in the output register and
// s_tready drops until the result is taken; a new request is accepted in the
// same cycle that the waiting result leaves.
// ---------------------------------------------------------------------------
module sorted_priority_queue import spq_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] proc_id, [31:16] priority_req
	input  logic [0:0]  s_tuser,   // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [15:0] head_proc_id, [31:16] head_priority,
	                               // [36:32] occupancy, [39:37] zero
	output logic [1:0]  m_tuser    // [0] head_valid, [1] overflow
);

	localparam int CW = $clog2(CAPACITY + 1);

	spq_cmd_t         cmd;
	logic [CW-1:0]    count;
	spq_entry_t       new_entry;
	spq_entry_t       dp_head;
	spq_entry_t       head_entry;
	logic             head_valid;
	logic             overflow;
	logic [OCC_W-1:0] occupancy;

	assign new_entry.proc_id      = s_tdata[15:0];
	assign new_entry.priority_val = s_tdata[31:16];

	// Controller owns the handshake, the count and the result register.
	spq_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.func      (s_tuser[0]),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.head_valid(head_valid),
		.head_entry(head_entry),
		.overflow  (overflow),
		.occupancy (occupancy),
		.cmd       (cmd),
		.count     (count),
		.dp_head   (dp_head)
	);

	// Datapath holds the sorted entry row.
	spq_datapath #(
		.CAPACITY(CAPACITY)
	) u_datapath (
		.clk      (clk),
		.cmd      (cmd),
		.count    (count),
		.new_entry(new_entry),
		.head     (dp_head)
	);

	assign m_tdata = {3'b000, occupancy, head_entry.priority_val, head_entry.proc_id};
	assign m_tuser = {overflow, head_valid};

endmodule
